// ===== rtl/core/awlm_pkg.sv =====
// shared types and constants of the a-weighted sound level meter
// no dependencies
package awlm_pkg;

  localparam int NUM_B = 7;
  localparam int NUM_A = 6;

  typedef logic signed [23:0] sample_t;
  typedef logic signed [47:0] yval_t;
  typedef logic [NUM_B-1:0][31:0] ff_coef_t;
  typedef logic [NUM_A-1:0][31:0] fb_coef_t;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_B0B1   = 3'd1;
  localparam logic [2:0] REG_B2B3   = 3'd2;
  localparam logic [2:0] REG_B4B5   = 3'd3;
  localparam logic [2:0] REG_B6A1   = 3'd4;
  localparam logic [2:0] REG_A2A3   = 3'd5;
  localparam logic [2:0] REG_A4A5   = 3'd6;
  localparam logic [2:0] REG_A6PER  = 3'd7;

  localparam logic [31:0] PERIOD_RESET = 32'd10000;

  localparam logic signed [56:0] Y_MAX = 57'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [56:0] Y_MIN = -57'sh0_8000_0000_0000;

  localparam logic signed [18:0] DB_PER_OCTAVE_Q16 = 19'sd197283;
  localparam logic signed [15:0] OFS_MODE16 = 16'sd2207;
  localparam logic signed [15:0] OFS_MODE24 = -16'sd3959;
  localparam logic signed [15:0] LEVEL_MIN  = -16'sd32768;
  localparam logic signed [15:0] LEVEL_MAX  = 16'sd32767;

endpackage

// ===== rtl/core/awlm_front.sv =====
// input side: sample decode by width mode and a two-entry queue to the back end
// depends on awlm_pkg
module awlm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_sample_word,
  input  logic                mode,
  output logic                q_valid,
  input  logic                q_pop,
  output awlm_pkg::sample_t   q_x
);
  import awlm_pkg::*;

  sample_t     ent_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push;
  sample_t     x_dec;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_x      = ent_r[rd_ptr_r];

  // 24-bit mode takes the word shifted right by 8, 16-bit mode the low half
  assign x_dec = mode ? sample_t'($signed(in_sample_word[31:8]))
                      : sample_t'($signed(in_sample_word[15:0]));

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= x_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/awlm_log2.sv =====
// iterative log2 in q16: binary-search normalize, then sixteen squaring steps
// no package dependencies
module awlm_log2 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [21:0] result
);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_NORM = 3'b010,
    L_SQ   = 3'b100
  } lst_t;

  lst_t        st_r;
  logic [63:0] v_r;
  logic [5:0]  e_r;
  logic [15:0] fr_r;
  logic [31:0] m_r;
  logic [3:0]  n_r;
  logic        done_r;

  logic [5:0]  sh;
  logic        topz;
  logic [63:0] vn;
  logic [63:0] sqm;
  logic [32:0] t;

  assign sh   = 6'd32 >> n_r[2:0];
  assign topz = ((v_r >> (7'd64 - {1'b0, sh})) == 64'd0);
  assign vn   = topz ? (v_r << sh) : v_r;
  assign sqm  = m_r * m_r;
  assign t    = sqm[63:31];

  assign done   = done_r;
  assign result = {e_r, fr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      n_r    <= 4'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        L_IDLE: begin
          if (start) begin
            v_r  <= value;
            e_r  <= 6'd63;
            n_r  <= 4'd0;
            st_r <= L_NORM;
          end
        end
        L_NORM: begin
          v_r <= vn;
          if (topz) begin
            e_r <= e_r - sh;
          end
          if (n_r == 4'd5) begin
            m_r  <= vn[63:32];
            fr_r <= 16'd0;
            n_r  <= 4'd0;
            st_r <= L_SQ;
          end else begin
            n_r <= n_r + 4'd1;
          end
        end
        L_SQ: begin
          if (t[32]) begin
            m_r  <= t[32:1];
            fr_r <= {fr_r[14:0], 1'b1};
          end else begin
            m_r  <= t[31:0];
            fr_r <= {fr_r[14:0], 1'b0};
          end
          n_r <= n_r + 4'd1;
          if (n_r == 4'd15) begin
            done_r <= 1'b1;
            st_r   <= L_IDLE;
          end
        end
        default: begin
          st_r <= L_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/awlm_back.sv =====
// back end: iir filter on multipliers shared by the taps, squaring, saturating sum, level and result register
// depends on awlm_pkg and awlm_log2
module awlm_back #(
  parameter int FF_TAPS = 7,
  parameter int FB_TAPS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  awlm_pkg::sample_t   q_x,
  input  logic                mode,
  input  awlm_pkg::ff_coef_t  b_coef,
  input  awlm_pkg::fb_coef_t  a_coef,
  input  logic [31:0]         period,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_level_dba
);
  import awlm_pkg::*;

  localparam logic [2:0] FF_LAST = 3'(FF_TAPS - 1);
  localparam logic [2:0] FB_LAST = 3'(FB_TAPS - 1);
  localparam logic signed [41:0] RND = 42'sh800000;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_FF   = 10'b0000000010,
    S_FB   = 10'b0000000100,
    S_SAT  = 10'b0000001000,
    S_SQ   = 10'b0000010000,
    S_SUM  = 10'b0000100000,
    S_LOGS = 10'b0001000000,
    S_LOGC = 10'b0010000000,
    S_FIN  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } st_t;

  st_t                st_r;
  logic [2:0]         k_r;
  logic [1:0]         ph_r;
  sample_t            xh_r [FF_TAPS];
  yval_t              yh_r [FB_TAPS];
  logic signed [56:0] acc_r;
  logic signed [65:0] prod_r;
  logic signed [64:0] plo_r;
  logic [47:0]        mag_r;
  logic [95:0]        sqa_r;
  logic [63:0]        sum_r;
  logic [31:0]        cnt_r;
  logic [21:0]        lgs_r;
  logic signed [41:0] lvp_r;
  logic signed [15:0] lvl_r;
  logic               out_valid_r;
  logic signed [15:0] out_level_r;

  logic signed [55:0] pff;
  logic signed [64:0] pl;
  logic signed [63:0] ph;
  logic signed [56:0] ysat;
  yval_t              y_n;
  logic [23:0]        mua;
  logic [23:0]        mub;
  logic [47:0]        mul24;
  logic [63:0]        sq;
  logic [64:0]        sum_add;
  logic [63:0]        sum_n;
  logic [31:0]        cnt_n;
  logic               lg_start;
  logic [63:0]        lg_val;
  logic               lg_done;
  logic [21:0]        lg_res;
  logic signed [22:0] d;
  logic signed [41:0] dprod;
  logic signed [41:0] rnd;
  logic signed [17:0] lsh;
  logic signed [18:0] lsum;
  logic signed [15:0] ofs;
  logic               out_load;

  assign q_pop = (st_r == S_IDLE) && q_valid;

  assign pff = xh_r[0] * $signed(b_coef[k_r]);
  assign pl  = yh_r[0] * $signed({1'b0, a_coef[k_r][15:0]});
  assign ph  = yh_r[0] * $signed(a_coef[k_r][31:16]);

  assign ysat = (acc_r > Y_MAX) ? Y_MAX : ((acc_r < Y_MIN) ? Y_MIN : acc_r);
  assign y_n  = ysat[47:0];

  // one 24x24 multiplier: low*low, low*high, high*high
  assign mua   = (ph_r == 2'd0) ? mag_r[23:0] : mag_r[47:24];
  assign mub   = (ph_r == 2'd2) ? mag_r[47:24] : mag_r[23:0];
  assign mul24 = mua * mub;

  assign sq = mode ? sqa_r[95:32]
                   : ((|sqa_r[95:88]) ? {64{1'b1}} : sqa_r[87:24]);
  assign sum_add = {1'b0, sum_r} + {1'b0, sq};
  assign sum_n   = sum_add[64] ? {64{1'b1}} : sum_add[63:0];
  assign cnt_n   = cnt_r + 32'd1;

  assign lg_start = ((st_r == S_LOGS) || (st_r == S_LOGC)) && (ph_r == 2'd0);
  assign lg_val   = (st_r == S_LOGS) ? sum_r : {32'd0, cnt_r};

  assign d     = $signed({1'b0, lgs_r}) - $signed({1'b0, lg_res});
  assign dprod = d * DB_PER_OCTAVE_Q16;
  assign rnd   = lvp_r + RND;
  assign lsh   = 18'(rnd >>> 24);
  assign ofs   = mode ? OFS_MODE24 : OFS_MODE16;
  assign lsum  = 19'(lsh) + 19'(ofs);

  assign out_load      = (st_r == S_OUT) && (!out_valid_r || out_ready);
  assign out_valid     = out_valid_r;
  assign out_level_dba = out_level_r;

  awlm_log2 u_log2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lg_start),
    .value  (lg_val),
    .done   (lg_done),
    .result (lg_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      k_r         <= 3'd0;
      ph_r        <= 2'd0;
      sum_r       <= 64'd0;
      cnt_r       <= 32'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < FF_TAPS; i++) begin
        xh_r[i] <= '0;
      end
      for (int i = 0; i < FB_TAPS; i++) begin
        yh_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            for (int i = FF_TAPS - 1; i > 0; i--) begin
              xh_r[i] <= xh_r[i-1];
            end
            xh_r[0] <= q_x;
            acc_r   <= '0;
            k_r     <= 3'd0;
            ph_r    <= 2'd0;
            st_r    <= S_FF;
          end
        end
        S_FF: begin
          if (ph_r == 2'd0) begin
            prod_r <= 66'(pff);
            ph_r   <= 2'd1;
          end else begin
            acc_r <= acc_r + 57'(prod_r >>> 12);
            // rotate so the next tap sits at the head
            for (int i = 0; i < FF_TAPS - 1; i++) begin
              xh_r[i] <= xh_r[i+1];
            end
            xh_r[FF_TAPS-1] <= xh_r[0];
            ph_r <= 2'd0;
            if (k_r == FF_LAST) begin
              k_r  <= 3'd0;
              st_r <= S_FB;
            end else begin
              k_r <= k_r + 3'd1;
            end
          end
        end
        S_FB: begin
          case (ph_r)
            2'd0: begin
              plo_r <= pl;
              ph_r  <= 2'd1;
            end
            2'd1: begin
              prod_r <= 66'(ph) + 66'(plo_r >>> 16);
              ph_r   <= 2'd2;
            end
            default: begin
              acc_r <= acc_r - 57'(prod_r >>> 12);
              for (int i = 0; i < FB_TAPS - 1; i++) begin
                yh_r[i] <= yh_r[i+1];
              end
              yh_r[FB_TAPS-1] <= yh_r[0];
              ph_r <= 2'd0;
              if (k_r == FB_LAST) begin
                k_r  <= 3'd0;
                st_r <= S_SAT;
              end else begin
                k_r <= k_r + 3'd1;
              end
            end
          endcase
        end
        S_SAT: begin
          for (int i = FB_TAPS - 1; i > 0; i--) begin
            yh_r[i] <= yh_r[i-1];
          end
          yh_r[0] <= y_n;
          mag_r   <= y_n[47] ? 48'(-ysat) : y_n;
          ph_r    <= 2'd0;
          st_r    <= S_SQ;
        end
        S_SQ: begin
          case (ph_r)
            2'd0: begin
              sqa_r <= 96'(mul24);
              ph_r  <= 2'd1;
            end
            2'd1: begin
              sqa_r <= sqa_r + 96'({mul24, 25'd0});
              ph_r  <= 2'd2;
            end
            default: begin
              sqa_r <= sqa_r + {mul24, 48'd0};
              ph_r  <= 2'd0;
              st_r  <= S_SUM;
            end
          endcase
        end
        S_SUM: begin
          sum_r <= sum_n;
          cnt_r <= cnt_n;
          if (cnt_n >= period) begin
            if (sum_n == 64'd0) begin
              lvl_r <= LEVEL_MIN;
              st_r  <= S_OUT;
            end else begin
              ph_r <= 2'd0;
              st_r <= S_LOGS;
            end
          end else begin
            st_r <= S_IDLE;
          end
        end
        S_LOGS: begin
          if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else if (lg_done) begin
            lgs_r <= lg_res;
            ph_r  <= 2'd0;
            st_r  <= S_LOGC;
          end
        end
        S_LOGC: begin
          if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else if (lg_done) begin
            lvp_r <= dprod;
            ph_r  <= 2'd0;
            st_r  <= S_FIN;
          end
        end
        S_FIN: begin
          if (lsum > 19'(LEVEL_MAX)) begin
            lvl_r <= LEVEL_MAX;
          end else if (lsum < 19'(LEVEL_MIN)) begin
            lvl_r <= LEVEL_MIN;
          end else begin
            lvl_r <= lsum[15:0];
          end
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_level_r <= lvl_r;
            out_valid_r <= 1'b1;
            sum_r       <= 64'd0;
            cnt_r       <= 32'd0;
            st_r        <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && sum_r == 64'd0 && cnt_r == 32'd0))
    else $error("sum or count not cleared after result transfer");

  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SQ) |-> (mag_r <= 48'h8000_0000_0000))
    else $error("filter output magnitude beyond saturated range");

  a_fin_after_log: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FIN) |-> $past(st_r == S_LOGC))
    else $error("level computed without log pass");
`endif

endmodule

// ===== rtl/core/a_weighted_sound_level_meter.sv =====
// top level of the a-weighted sound level meter: configuration registers, front and back end
// depends on awlm_pkg, awlm_front, awlm_back
//
//   channel   direction  handshake               payload
//   in_       input      in_valid / in_ready     in_sample_word[31:0]
//   out_      output     out_valid / out_ready   out_level_dba[15:0] signed
//   cfg_      input      cfg_we                  cfg_index[2:0], cfg_wdata[63:0]
//
// a sample is worked through the back end one tap at a time, on multipliers that the taps share
// a sample that closes a period adds two log2 passes
// reset is synchronous and active low; coefficients clear, the period returns to 10000
// a two-entry queue takes new samples while the back end works or a result waits
module a_weighted_sound_level_meter #(
  parameter int FEEDFORWARD_TAPS = 7,
  parameter int FEEDBACK_TAPS    = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_sample_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_level_dba,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);
  import awlm_pkg::*;

  logic        mode_r;
  ff_coef_t    b_coef_r;
  fb_coef_t    a_coef_r;
  logic [31:0] period_r;

  logic        q_valid;
  logic        q_pop;
  sample_t     q_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      b_coef_r <= '0;
      a_coef_r <= '0;
      period_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE: begin
          mode_r <= cfg_wdata[0];
        end
        REG_B0B1: begin
          b_coef_r[0] <= cfg_wdata[31:0];
          b_coef_r[1] <= cfg_wdata[63:32];
        end
        REG_B2B3: begin
          b_coef_r[2] <= cfg_wdata[31:0];
          b_coef_r[3] <= cfg_wdata[63:32];
        end
        REG_B4B5: begin
          b_coef_r[4] <= cfg_wdata[31:0];
          b_coef_r[5] <= cfg_wdata[63:32];
        end
        REG_B6A1: begin
          b_coef_r[6] <= cfg_wdata[31:0];
          a_coef_r[0] <= cfg_wdata[63:32];
        end
        REG_A2A3: begin
          a_coef_r[1] <= cfg_wdata[31:0];
          a_coef_r[2] <= cfg_wdata[63:32];
        end
        REG_A4A5: begin
          a_coef_r[3] <= cfg_wdata[31:0];
          a_coef_r[4] <= cfg_wdata[63:32];
        end
        REG_A6PER: begin
          a_coef_r[5] <= cfg_wdata[31:0];
          period_r    <= cfg_wdata[63:32];
        end
        default: begin
          mode_r <= mode_r;
        end
      endcase
    end
  end

  awlm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_word (in_sample_word),
    .mode           (mode_r),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_x            (q_x)
  );

  awlm_back #(
    .FF_TAPS (FEEDFORWARD_TAPS),
    .FB_TAPS (FEEDBACK_TAPS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_x           (q_x),
    .mode          (mode_r),
    .b_coef        (b_coef_r),
    .a_coef        (a_coef_r),
    .period        (period_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_level_dba (out_level_dba)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for a_weighted_sound_level_meter: directed and random samples
// run through a predictor of the weighting filter and level math, results checked in order
// depends on awlm_pkg and the a_weighted_sound_level_meter rtl
module tb_top;
  import awlm_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        in_sample_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_level_dba;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_wdata = '0;

  a_weighted_sound_level_meter dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic                mode_24;
  logic signed [31:0]  ff_c [0:6];
  logic signed [31:0]  fb_c [1:6];
  logic [31:0]         period_len;
  logic signed [63:0]  x_hist [0:6];
  logic signed [63:0]  y_hist [0:5];
  int                  x_pos, y_pos;
  logic [63:0]         sq_sum;
  logic [63:0]         samp_cnt;

  logic signed [15:0] level_q [$];
  int  mismatches = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_gen = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  function automatic logic signed [63:0] mul_q28(input logic signed [63:0] v,
                                                 input logic signed [31:0] c);
    logic signed [95:0] p;
    p = v * c;
    return 64'(p >>> 28);
  endfunction

  function automatic logic [63:0] log2_q16(input logic [63:0] v);
    int e;
    logic [63:0] m;
    logic [127:0] t;
    logic [63:0] frac;
    e = 63;
    frac = '0;
    while (e > 0 && !v[e]) e--;
    m = (e >= 31) ? (v >> (e - 31)) : (v << (31 - e));
    for (int i = 0; i < 16; i++) begin
      t = ({64'b0, m} * {64'b0, m}) >> 31;
      m = t[63:0];
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return 64'(e) * 65536 + frac;
  endfunction

  task automatic load_reg(input logic [2:0] idx, input logic [63:0] val);
    case (idx)
      REG_MODE:  mode_24 = val[0];
      REG_B0B1:  begin ff_c[0] = val[31:0]; ff_c[1] = val[63:32]; end
      REG_B2B3:  begin ff_c[2] = val[31:0]; ff_c[3] = val[63:32]; end
      REG_B4B5:  begin ff_c[4] = val[31:0]; ff_c[5] = val[63:32]; end
      REG_B6A1:  begin ff_c[6] = val[31:0]; fb_c[1] = val[63:32]; end
      REG_A2A3:  begin fb_c[2] = val[31:0]; fb_c[3] = val[63:32]; end
      REG_A4A5:  begin fb_c[4] = val[31:0]; fb_c[5] = val[63:32]; end
      REG_A6PER: begin fb_c[6] = val[31:0]; period_len = val[63:32]; end
      default: ;
    endcase
  endtask

  task automatic predict_level(input logic [31:0] w);
    logic signed [63:0] acc_b, acc_a, y, ay, d, lvl;
    logic [127:0] sq;
    logic [63:0] sq64;
    acc_b = 0;
    acc_a = 0;
    x_hist[x_pos] = mode_24 ? 64'($signed(w[31:8])) : 64'($signed(w[15:0]));
    for (int k = 0; k < 7; k++)
      acc_b += mul_q28(x_hist[(x_pos + 7 - k) % 7] * 65536, ff_c[k]);
    for (int k = 1; k <= 6; k++)
      acc_a += mul_q28(y_hist[(y_pos + 6 - k) % 6], fb_c[k]);
    y = acc_b - acc_a;
    if (y > 64'sh7FFF_FFFF_FFFF) y = 64'sh7FFF_FFFF_FFFF;
    if (y < -64'sh8000_0000_0000) y = -64'sh8000_0000_0000;
    y_hist[y_pos] = y;
    x_pos = (x_pos + 1) % 7;
    y_pos = (y_pos + 1) % 6;
    ay = (y < 0) ? -y : y;
    sq = ({64'b0, ay} * {64'b0, ay}) >> (mode_24 ? 32 : 24);
    sq64 = (sq[127:64] != 0) ? '1 : sq[63:0];
    sq_sum = (sq_sum > ~sq64) ? '1 : sq_sum + sq64;
    samp_cnt++;
    if (samp_cnt >= {32'b0, period_len}) begin
      if (sq_sum == 0) begin
        lvl = LEVEL_MIN;
      end else begin
        d = $signed(log2_q16(sq_sum)) - $signed(log2_q16(samp_cnt));
        lvl = (d * 197283 + (64'sd1 <<< 23)) >>> 24;
        lvl += mode_24 ? OFS_MODE24 : OFS_MODE16;
        if (lvl > 32767) lvl = 32767;
        if (lvl < -32768) lvl = -32768;
      end
      level_q.push_back(16'(lvl));
      sq_sum = 0;
      samp_cnt = 0;
    end
  endtask

  task automatic send_sample(input logic [31:0] w);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_word <= w;
    do @(posedge clk); while (!in_ready);
    predict_level(w);
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (level_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    load_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_filter(input logic [31:0] c [0:12], input logic [31:0] per);
    write_reg(REG_B0B1, {c[1], c[0]});
    write_reg(REG_B2B3, {c[3], c[2]});
    write_reg(REG_B4B5, {c[5], c[4]});
    write_reg(REG_B6A1, {c[7], c[6]});
    write_reg(REG_A2A3, {c[9], c[8]});
    write_reg(REG_A4A5, {c[11], c[10]});
    write_reg(REG_A6PER, {per, c[12]});
  endtask

  task automatic unity_filter(input logic [31:0] per);
    logic [31:0] c [0:12];
    foreach (c[i]) c[i] = '0;
    c[0] = 32'h1000_0000;
    load_filter(c, per);
  endtask

  task automatic random_filter();
    logic [31:0] c [0:12];
    logic [31:0] per;
    int wild;
    wild = ($urandom_range(9) == 0);
    foreach (c[i]) begin
      if (wild) c[i] = $urandom();
      else if (i < 7) c[i] = 32'($urandom_range(0, 1 << 28)) - 32'(1 << 27);
      else c[i] = 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
    end
    per = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
    load_filter(c, per);
  endtask

  task automatic test_empty_sum();
    unity_filter(32'd0);
    write_reg(REG_B0B1, 64'd0);
    repeat (3) send_sample($urandom());
    settle();
  endtask

  task automatic test_narrow_extremes();
    unity_filter(32'd1);
    send_sample(32'h0000_7FFF);
    send_sample(32'hFFFF_8000);
    send_sample(32'h1234_0000);
    send_sample(32'hABCD_0001);
    send_sample(32'h0000_FFFF);
    settle();
  endtask

  task automatic test_wide_mode();
    write_reg(REG_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_01FF);
    settle();
    write_reg(REG_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
    send_sample(32'h0000_8000);
    settle();
  endtask

  task automatic test_saturation();
    logic [31:0] c [0:12];
    foreach (c[i]) c[i] = '0;
    c[0] = 32'h7FFF_FFFF;
    c[6] = 32'h8000_0000;
    c[7] = 32'h8000_0000;
    load_filter(c, 32'd3);
    repeat (6) send_sample(32'h7FFF_7FFF);
    settle();
    write_reg(REG_MODE, 64'd1);
    repeat (3) send_sample(32'h8000_0000);
    settle();
    write_reg(REG_MODE, 64'd0);
  endtask

  task automatic test_period_drop();
    unity_filter(32'd10);
    repeat (5) send_sample($urandom());
    settle();
    write_reg(REG_A6PER, {32'd2, 32'd0});
    send_sample($urandom());
    settle();
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) begin
        settle();
        write_reg(REG_MODE, {63'($urandom()), 1'($urandom())});
        random_filter();
      end
      send_sample($urandom());
    end
    settle();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_MODE, 64'd0);
    unity_filter(32'd0);
    hold_gen++;
    for (int i = 0; i < 40; i++) send_sample($urandom());
    settle();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_gen) begin
      hold_seen <= hold_gen;
      hold_left <= 600;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (level_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected level transfer: level_dba %0d", out_level_dba);
      end else begin
        if (out_level_dba !== level_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("level_dba mismatch: expected %0d actual %0d", level_q[0], out_level_dba);
        end
        void'(level_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("a_weighted_sound_level_meter verification failed");
      $finish;
    end
  end

  initial begin
    mode_24 = 1'b0;
    foreach (ff_c[i]) ff_c[i] = '0;
    foreach (fb_c[i]) fb_c[i] = '0;
    period_len = PERIOD_RESET;
    foreach (x_hist[i]) x_hist[i] = '0;
    foreach (y_hist[i]) y_hist[i] = '0;
    x_pos = 0;
    y_pos = 0;
    sq_sum = '0;
    samp_cnt = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_sum();
    test_narrow_extremes();
    test_wide_mode();
    test_saturation();
    test_period_drop();
    test_random(400, 0, 0);
    test_random(400, 45, 0);
    test_random(400, 0, 45);
    test_random(400, 38, 38);
    test_backpressure();
    if (level_q.size() != 0) mismatches++;
    if (mismatches == 0)
      $display("a_weighted_sound_level_meter verification clean");
    else
      $display("a_weighted_sound_level_meter verification failed");
    $finish;
  end

endmodule

// ===== a_weighted_sound_level_meter.f =====
rtl/core/awlm_pkg.sv
rtl/core/awlm_front.sv
rtl/core/awlm_log2.sv
rtl/core/awlm_back.sv
rtl/core/a_weighted_sound_level_meter.sv
tb/sv/tb_top.sv
